@@ src/rgpc_pkg.sv @@
// shared types, constants and register codes for the ray ground point classifier
`default_nettype none

package rgpc_pkg;

  // point index width carried through to the result
  localparam int INDEX_BITS = 16;

  // field widths
  localparam int RADIUS_W = 18;
  localparam int HEIGHT_W = 16;
  localparam int SENSOR_W = 14;
  localparam int TAN_W    = 16;
  localparam int NEAR_W   = 12;
  localparam int FRAC_W   = 12;

  // configuration bus
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // register reset values
  localparam logic [SENSOR_W-1:0] SENSOR_RST    = 14'd2000;
  localparam logic [TAN_W-1:0]    TAN_LOCAL_RST = 16'd722;
  localparam logic [TAN_W-1:0]    TAN_GEN_RST   = 16'd286;
  localparam logic [NEAR_W-1:0]   NEAR_RST      = 12'd150;

  // word index of each register
  typedef enum logic [1:0] {
    RegSensorHeight = 2'd0,
    RegTanLocal     = 2'd1,
    RegTanGeneral   = 2'd2,
    RegNearDistance = 2'd3
  } reg_idx_t;

  // current register contents
  typedef struct packed {
    logic [SENSOR_W-1:0] sensor_height_mm;
    logic [TAN_W-1:0]    tan_local_q12;
    logic [TAN_W-1:0]    tan_general_q12;
    logic [NEAR_W-1:0]   near_distance_mm;
  } cfg_t;

  // previous kept point of the ray
  typedef struct packed {
    logic [RADIUS_W-1:0]        radius;
    logic signed [HEIGHT_W-1:0] height;
    logic                       ground;
  } ray_state_t;

  // classification of one point
  typedef struct packed {
    logic       keep;
    logic       ground;
    ray_state_t base;
  } cls_t;

endpackage

`default_nettype wire

@@ src/ray_ground_point_classifier.sv @@
// top level: input register, point classification, ray state and result register
`default_nettype none

// Ray ground point classifier. Points enter one per transaction, grouped by ray
// and sorted by radius, first_of_ray set on the first point of each ray. A point
// within near_distance_mm of the previous kept point in both height and radius
// is dropped and produces no result transaction; every other point produces one
// result carrying its index and a ground flag. The block takes one point every
// cycle unless a result waits stalled with a point in the input register: a
// point is captured in the input register, then classified and folded into the
// ray state in one combinational step on its way to the result register, which
// offers its result. That step (two 16x18 slope products and their compares,
// feeding the previous-point registers) sets the clock limit. The output
// register lets a new point enter while a result waits. Configuration is written
// over the APB-style port while no points are in flight; a new sensor height
// applies to the global test at once and to the ray state at the next ray start.
module ray_ground_point_classifier
  import rgpc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // point input
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic        [RADIUS_W-1:0] in_radius_mm,
  input  wire logic signed [HEIGHT_W-1:0] in_height_mm,
  input  wire logic      [INDEX_BITS-1:0] in_point_index,
  input  wire logic                       in_first_of_ray,
  // result output
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic           [INDEX_BITS-1:0] out_index_out,
  output logic                            out_is_ground,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic         [ADDR_W-1:0]  paddr,
  input  wire logic         [DATA_W-1:0]  pwdata,
  output logic              [DATA_W-1:0]  prdata,
  output logic                            pready
);

  cfg_t                       cfg;
  cls_t                       cls;

  logic                       s1_valid_r;
  logic [RADIUS_W-1:0]        s1_radius_r;
  logic signed [HEIGHT_W-1:0] s1_height_r;
  logic [INDEX_BITS-1:0]      s1_index_r;
  logic                       s1_first_r;

  ray_state_t                 state_r;
  ray_state_t                 state_nxt;

  logic                       out_valid_r;
  logic [INDEX_BITS-1:0]      out_index_r;
  logic                       out_ground_r;

  logic                       adv;
  logic                       proc;

  rgpc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rgpc_classify u_classify (
    .cfg    (cfg),
    .prev   (state_r),
    .radius (s1_radius_r),
    .height (s1_height_r),
    .first  (s1_first_r),
    .cls    (cls)
  );

  // pipeline moves when the result register is free or being emptied
  assign adv      = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  // input register, refilled whenever it is empty or being processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_radius_r <= in_radius_mm;
      s1_height_r <= in_height_mm;
      s1_index_r  <= in_point_index;
      s1_first_r  <= in_first_of_ray;
    end
  end

  // previous kept point; a dropped ray start still restarts the ray
  always_comb begin
    state_nxt = state_r;
    if (proc) begin
      if (cls.keep) begin
        state_nxt.radius = s1_radius_r;
        state_nxt.height = s1_height_r;
        state_nxt.ground = cls.ground;
      end else begin
        state_nxt = cls.base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.radius <= '0;
      state_r.height <= HEIGHT_W'(-$signed({2'b00, SENSOR_RST}));
      state_r.ground <= 1'b1;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r && cls.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && cls.keep) begin
      out_index_r  <= s1_index_r;
      out_ground_r <= cls.ground;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index_out = out_index_r;
  assign out_is_ground = out_ground_r;

`ifndef SYNTHESIS
  // input is held back only behind a waiting point
  a_stall_needs_point: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // a new result comes only from a point that was processed
  a_result_from_point: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a point");

  // ray state changes only when a point is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(proc)) |-> $stable(state_r))
    else $error("ray state changed with no point processed");

  // a stalled result is never overwritten
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(out_valid_r && out_stall))
      |-> (out_valid_r && $stable(out_index_r) && $stable(out_ground_r)))
    else $error("stalled result lost or changed");
`endif

endmodule

`default_nettype wire

@@ src/rgpc_regs.sv @@
// configuration register file behind the apb-style port
`default_nettype none

module rgpc_regs
  import rgpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        RegSensorHeight: cfg_nxt.sensor_height_mm = pwdata[SENSOR_W-1:0];
        RegTanLocal:     cfg_nxt.tan_local_q12    = pwdata[TAN_W-1:0];
        RegTanGeneral:   cfg_nxt.tan_general_q12  = pwdata[TAN_W-1:0];
        RegNearDistance: cfg_nxt.near_distance_mm = pwdata[NEAR_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sensor_height_mm <= SENSOR_RST;
      cfg_r.tan_local_q12    <= TAN_LOCAL_RST;
      cfg_r.tan_general_q12  <= TAN_GEN_RST;
      cfg_r.near_distance_mm <= NEAR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read decode
  always_comb begin
    unique case (idx)
      RegSensorHeight: prdata = DATA_W'(cfg_r.sensor_height_mm);
      RegTanLocal:     prdata = DATA_W'(cfg_r.tan_local_q12);
      RegTanGeneral:   prdata = DATA_W'(cfg_r.tan_general_q12);
      RegNearDistance: prdata = DATA_W'(cfg_r.near_distance_mm);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/rgpc_classify.sv @@
// duplicate test and local/global slope tests for one point
`default_nettype none

module rgpc_classify
  import rgpc_pkg::*;
(
  input  wire cfg_t                        cfg,
  input  wire ray_state_t                  prev,
  input  wire logic        [RADIUS_W-1:0]  radius,
  input  wire logic signed [HEIGHT_W-1:0]  height,
  input  wire logic                        first,
  output cls_t                             cls
);

  ray_state_t                base;
  logic [HEIGHT_W:0]         dz_diff;
  logic [HEIGHT_W-1:0]       dz_abs;
  logic [RADIUS_W:0]         dr_diff;
  logic [RADIUS_W-1:0]       dr_abs;
  logic                      dr_back;
  logic [HEIGHT_W:0]         gz_sum;
  logic [HEIGHT_W-1:0]       gz_abs;
  logic                      dup;
  logic [HEIGHT_W+FRAC_W-1:0] loc_lhs;
  logic [HEIGHT_W+FRAC_W-1:0] gen_lhs;
  logic [TAN_W+RADIUS_W-1:0] loc_rhs;
  logic [TAN_W+RADIUS_W-1:0] gen_rhs;
  logic                      local_ok;
  logic                      global_ok;
  logic                      ground;

  // a new ray starts from the ground under the sensor
  always_comb begin
    if (first) begin
      base.radius = '0;
      base.height = HEIGHT_W'(-$signed({2'b00, cfg.sensor_height_mm}));
      base.ground = 1'b1;
    end else begin
      base = prev;
    end
  end

  // distances to the previous point
  assign dz_diff = {height[HEIGHT_W-1], height} - {base.height[HEIGHT_W-1], base.height};
  assign dz_abs  = dz_diff[HEIGHT_W] ? HEIGHT_W'(-dz_diff) : dz_diff[HEIGHT_W-1:0];
  assign dr_diff = {1'b0, radius} - {1'b0, base.radius};
  assign dr_back = dr_diff[RADIUS_W];
  assign dr_abs  = dr_back ? RADIUS_W'(-dr_diff) : dr_diff[RADIUS_W-1:0];

  // height above the ground under the sensor
  assign gz_sum = {height[HEIGHT_W-1], height}
                + {{(HEIGHT_W+1-SENSOR_W){1'b0}}, cfg.sensor_height_mm};
  assign gz_abs = gz_sum[HEIGHT_W] ? HEIGHT_W'(-gz_sum) : gz_sum[HEIGHT_W-1:0];

  // near duplicate of the previous point
  assign dup = (dz_abs <= HEIGHT_W'(cfg.near_distance_mm))
            && (dr_abs <= RADIUS_W'(cfg.near_distance_mm));

  // slope tests: |dz| * 2^12 <= tan * dr
  assign loc_lhs   = {dz_abs, {FRAC_W{1'b0}}};
  assign gen_lhs   = {gz_abs, {FRAC_W{1'b0}}};
  assign loc_rhs   = cfg.tan_local_q12 * dr_abs;
  assign gen_rhs   = cfg.tan_general_q12 * radius;
  assign local_ok  = !dr_back && ((TAN_W+RADIUS_W)'(loc_lhs) <= loc_rhs);
  assign global_ok = (TAN_W+RADIUS_W)'(gen_lhs) <= gen_rhs;

  // class decision
  always_comb begin
    if (first) begin
      ground = global_ok;
    end else if (local_ok) begin
      ground = base.ground || global_ok;
    end else begin
      ground = 1'b0;
    end
  end

  assign cls.keep   = !dup;
  assign cls.ground = ground;
  assign cls.base   = base;

endmodule

`default_nettype wire

@@ tb/ray_ground_point_classifier_tb.sv @@
// self-checking testbench for the ray ground point classifier: directed table, random rays
module ray_ground_point_classifier_tb;
  import rgpc_pkg::*;

  localparam int PHASES         = 7;
  localparam int POINTS_PER_SET = 200;
  localparam int DRAIN_CYCLES   = 4;
  localparam int END_CYCLES     = 8;
  localparam int HOLD_CYCLES    = 400;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int MAX_PRINTED    = 40;
  localparam int DIRECTED_ROWS  = 18;

  // what a directed row is known to produce, or left to the predictor
  typedef enum logic [1:0] {WantAny, WantDrop, WantGround, WantNonGround} want_e;

  typedef struct packed {
    logic [RADIUS_W-1:0]        radius;
    logic signed [HEIGHT_W-1:0] height;
    logic [INDEX_BITS-1:0]      index;
    logic                       first;
    want_e                      want;
  } point_row_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic                  ground;
  } class_result_t;

  // dut signals
  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [RADIUS_W-1:0]         in_radius_mm = '0;
  logic signed [HEIGHT_W-1:0]  in_height_mm = '0;
  logic [INDEX_BITS-1:0]       in_point_index = '0;
  logic                        in_first_of_ray = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [INDEX_BITS-1:0]       out_index_out;
  logic                        out_is_ground;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ADDR_W-1:0]           paddr = '0;
  logic [DATA_W-1:0]           pwdata = '0;
  logic [DATA_W-1:0]           prdata;
  logic                        pready;

  // predictor copy of registers and ray state
  logic [SENSOR_W-1:0] cfg_sensor;
  logic [TAN_W-1:0]    cfg_tan_local;
  logic [TAN_W-1:0]    cfg_tan_general;
  logic [NEAR_W-1:0]   cfg_near;
  int                  prev_radius;
  int                  prev_height;
  logic                prev_ground;

  // random ray generator state
  int ray_radius = 0;
  int ray_height = 0;
  int ray_left = 0;

  class_result_t pending_results[$];
  class_result_t oldest_result;

  int errors = 0;
  int cycle_count = 0;
  int points_sent = 0;
  int points_dropped = 0;
  int results_checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // directed points at reset register values (sensor 2000, near 150)
  point_row_t directed_points [DIRECTED_ROWS] = '{
    '{18'd0,      -16'sd2000,  16'h0000, 1'b1, WantDrop},       // same as fresh ray state
    '{18'd150,    -16'sd1850,  16'h0001, 1'b1, WantDrop},       // exactly at near distance
    '{18'd151,    -16'sd2000,  16'h0002, 1'b1, WantGround},     // just past near distance
    '{18'd0,      -16'sd1000,  16'h0003, 1'b1, WantNonGround},  // zero radius, off the ground
    '{18'd0,      -16'sd1000,  16'h0004, 1'b0, WantDrop},       // duplicate of kept point
    '{18'd0,      -16'sd500,   16'h0005, 1'b0, WantNonGround},  // zero local step
    '{18'd10000,  -16'sd2000,  16'hFFFF, 1'b1, WantGround},     // on the ground plane
    '{18'd5000,   -16'sd2000,  16'h0007, 1'b0, WantNonGround},  // radius going backwards
    '{18'd6000,   -16'sd2000,  16'h0008, 1'b0, WantAny},        // global fallback
    '{18'd7000,   -16'sd1990,  16'h0009, 1'b0, WantAny},        // inherits ground
    '{18'd9000,   16'sd1000,   16'h000A, 1'b0, WantAny},        // steep step
    '{18'd9100,   16'sd1000,   16'h000B, 1'b0, WantAny},
    '{18'd9500,   16'sd1005,   16'h000C, 1'b0, WantAny},
    '{18'h3FFFF,  16'sh7FFF,   16'h000D, 1'b1, WantAny},
    '{18'h3FFFF,  -16'sh8000,  16'h000E, 1'b0, WantAny},
    '{18'h3FFFF,  -16'sh8000,  16'h8000, 1'b1, WantAny},
    '{18'd0,      16'sd0,      16'h5555, 1'b1, WantAny},
    '{18'h2AAAA,  16'sh5555,   16'hAAAA, 1'b0, WantAny}
  };

  ray_ground_point_classifier u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_radius_mm   (in_radius_mm),
    .in_height_mm   (in_height_mm),
    .in_point_index (in_point_index),
    .in_first_of_ray(in_first_of_ray),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_index_out  (out_index_out),
    .out_is_ground  (out_is_ground),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               pending_results.size());
      $display("FAIL ray_ground_point_classifier");
      $finish;
    end
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // |dz| <= tan * dr with tan in Q4.12
  function automatic logic within_slope(input longint dz, input longint dr, input longint tan_q12);
    return (dz * 4096) <= (tan_q12 * dr);
  endfunction

  function automatic void reset_predictor();
    cfg_sensor      = SENSOR_RST;
    cfg_tan_local   = TAN_LOCAL_RST;
    cfg_tan_general = TAN_GEN_RST;
    cfg_near        = NEAR_RST;
    prev_radius     = 0;
    prev_height     = -int'(cfg_sensor);
    prev_ground     = 1'b1;
  endfunction

  // classify one point against the ray state and fold it in when kept
  function automatic void classify_point(input logic [RADIUS_W-1:0] r,
                                         input logic signed [HEIGHT_W-1:0] h,
                                         input logic first, output logic kept,
                                         output logic ground);
    int hv;
    int rv;
    int dz;
    int dr;
    hv = int'(h);
    rv = int'(r);
    if (first) begin
      prev_radius = 0;
      prev_height = -int'(cfg_sensor);
      prev_ground = 1'b1;
    end
    dz = magnitude(hv - prev_height);
    dr = magnitude(rv - prev_radius);
    kept = !(dz <= int'(cfg_near) && dr <= int'(cfg_near));
    ground = 1'b0;
    if (!kept) return;
    if (first) begin
      ground = within_slope(magnitude(hv + int'(cfg_sensor)), rv, cfg_tan_general);
    end else if (rv >= prev_radius && within_slope(dz, rv - prev_radius, cfg_tan_local)) begin
      ground = prev_ground ? 1'b1
                           : within_slope(magnitude(hv + int'(cfg_sensor)), rv, cfg_tan_general);
    end
    prev_radius = rv;
    prev_height = hv;
    prev_ground = ground;
  endfunction

  // result side: check each transaction, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result index %0h ground %0b", out_index_out,
                         out_is_ground));
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_index_out !== oldest_result.index)
          report($sformatf("index_out %0h, expected %0h", out_index_out, oldest_result.index));
        if (out_is_ground !== oldest_result.ground)
          report($sformatf("is_ground %0b, expected %0b for index %0h", out_is_ground,
                           oldest_result.ground, oldest_result.index));
        results_checked++;
      end
    end
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) hold_left--;
    out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // offer one point, wait for the transaction, then record what it should produce
  task automatic send_point(input logic [RADIUS_W-1:0] r, input logic signed [HEIGHT_W-1:0] h,
                            input logic [INDEX_BITS-1:0] idx, input logic first,
                            input want_e want);
    logic          kept;
    logic          ground;
    class_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_radius_mm    <= r;
    in_height_mm    <= h;
    in_point_index  <= idx;
    in_first_of_ray <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    points_sent++;
    classify_point(r, h, first, kept, ground);
    if (want != WantAny) begin
      if (kept != (want != WantDrop) || (kept && ground != (want == WantGround)))
        report($sformatf("directed point %0h: predictor disagrees with table", idx));
      kept   = (want != WantDrop);
      ground = (want == WantGround);
    end
    if (kept) begin
      res.index  = idx;
      res.ground = ground;
      pending_results.insert(pending_results.size(), res);
    end else begin
      points_dropped++;
    end
  endtask

  // next point of a random ray: mostly plausible rays, some duplicates, reversals and noise
  task automatic next_point(output logic [RADIUS_W-1:0] r, output logic signed [HEIGHT_W-1:0] h,
                            output logic [INDEX_BITS-1:0] idx, output logic first);
    int pick;
    int step;
    int k;
    first = 1'b0;
    pick = $urandom_range(0, 99);
    if (ray_left <= 0 || pick < 4) begin
      first = 1'b1;
      ray_left = $urandom_range(2, 24);
      ray_radius = $urandom_range(0, 4000);
      ray_height = -int'(cfg_sensor) + int'($urandom_range(0, 300)) - 150;
    end else if (pick < 62) begin
      // gently sloped ground
      step = $urandom_range(1, 1500);
      k = step / 12 + 1;
      ray_radius += step;
      ray_height += int'($urandom_range(0, 2 * k)) - k;
    end else if (pick < 76) begin
      // obstacle rising out of the ground
      ray_radius += int'($urandom_range(0, 400));
      ray_height += int'($urandom_range(100, 4000));
    end else if (pick < 86) begin
      // near the previous point, around the duplicate boundary
      ray_radius += int'($urandom_range(0, int'(cfg_near) + 2));
      ray_height += int'($urandom_range(0, 2 * int'(cfg_near) + 4)) - int'(cfg_near) - 2;
    end else if (pick < 92) begin
      ray_radius -= int'($urandom_range(1, 3000));
    end else begin
      ray_radius = $urandom_range(0, 262143);
      ray_height = int'($urandom_range(0, 65535)) - 32768;
    end
    ray_left--;
    ray_radius = clamp(ray_radius, 0, 262143);
    ray_height = clamp(ray_height, -32768, 32767);
    r = RADIUS_W'(ray_radius);
    h = HEIGHT_W'(ray_height);
    idx = INDEX_BITS'($urandom);
  endtask

  // apb write with junk above the field, then read it back
  task automatic write_and_verify_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] got;
    case (idx)
      RegSensorHeight: mask = (32'd1 << SENSOR_W) - 1;
      RegNearDistance: mask = (32'd1 << NEAR_W) - 1;
      default:         mask = (32'd1 << TAN_W) - 1;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~mask) | (value & mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      RegSensorHeight: cfg_sensor = value[SENSOR_W-1:0];
      RegTanLocal:     cfg_tan_local = value[TAN_W-1:0];
      RegTanGeneral:   cfg_tan_general = value[TAN_W-1:0];
      RegNearDistance: cfg_near = value[NEAR_W-1:0];
      default: ;
    endcase
    // read phase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== (value & mask))
      report($sformatf("register %s reads %0h, expected %0h", idx.name(), got, value & mask));
  endtask

  task automatic configure(input int phase);
    logic [DATA_W-1:0] sh;
    logic [DATA_W-1:0] tl;
    logic [DATA_W-1:0] tg;
    logic [DATA_W-1:0] nd;
    case (phase)
      0:       begin sh = 1800;  tl = 1200;  tg = 400;   nd = 100;  end
      1:       begin sh = 16383; tl = 65535; tg = 65535; nd = 4095; end
      2:       begin sh = 0;     tl = 0;     tg = 0;     nd = 0;    end
      4:       begin
        sh = DATA_W'(SENSOR_RST);
        tl = DATA_W'(TAN_LOCAL_RST);
        tg = DATA_W'(TAN_GEN_RST);
        nd = DATA_W'(NEAR_RST);
      end
      6:       begin sh = 500;   tl = 4096;  tg = 2048;  nd = 20;   end
      default: begin
        sh = $urandom_range(0, 16383);
        tl = $urandom_range(0, 8192);
        tg = $urandom_range(0, 4096);
        nd = $urandom_range(0, 400);
      end
    endcase
    write_and_verify_reg(RegSensorHeight, sh);
    write_and_verify_reg(RegTanLocal, tl);
    write_and_verify_reg(RegTanGeneral, tg);
    write_and_verify_reg(RegNearDistance, nd);
  endtask

  // let every expected result arrive, plus the pipeline depth for dropped points
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [RADIUS_W-1:0]        r;
    logic signed [HEIGHT_W-1:0] h;
    logic [INDEX_BITS-1:0]      idx;
    logic                       first;
    reset_predictor();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct <= 78;
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_point(directed_points[i].radius, directed_points[i].height,
                 directed_points[i].index, directed_points[i].first, directed_points[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == 2) begin
        send_idle_pct = 78;
        recv_idle_pct <= 19;
      end else if (p == 5) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      configure(p);
      for (int i = 0; i < POINTS_PER_SET; i++) begin
        // long output hold while points keep coming
        if (p == PHASES - 1 && i == 10) hold_asked <= hold_asked + 1;
        next_point(r, h, idx, first);
        send_point(r, h, idx, first, WantAny);
      end
    end

    drain();
    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d points (%0d directed), %0d results checked, %0d dropped as duplicates",
             points_sent, DIRECTED_ROWS, results_checked, points_dropped);
    $display("reset values plus %0d register settings incl. all-zero and full-scale, three idling mixes",
             PHASES);
    if (errors == 0) begin
      $display("PASS ray_ground_point_classifier");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL ray_ground_point_classifier");
    end
    $finish;
  end

endmodule
